// File: rtl/thsl_pkg.sv
// shared types and constants for the tar header stream lister
`timescale 1ns / 1ps

package thsl_pkg;

    localparam int unsigned BLOCK_BYTES      = 512;
    localparam int unsigned OFFSET_W         = $clog2(BLOCK_BYTES);
    localparam int unsigned SIZE_W           = 36;
    localparam int unsigned SKIP_W           = SIZE_W + 1;

    localparam logic [OFFSET_W-1:0] BLOCK_LAST   = OFFSET_W'(BLOCK_BYTES - 1);
    localparam logic [OFFSET_W-1:0] NAME_LEN     = OFFSET_W'(100);
    localparam logic [OFFSET_W-1:0] SIZE_START   = OFFSET_W'(124);
    localparam logic [OFFSET_W-1:0] SIZE_END     = OFFSET_W'(124 + 12);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SEVEN = 8'h37;

    localparam logic [1:0] KIND_NAME    = 2'd0;
    localparam logic [1:0] KIND_COMMIT  = 2'd1;
    localparam logic [1:0] KIND_DISCARD = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    typedef struct packed {
        logic [7:0] archive_byte;
        logic       stream_end;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] name_byte;
        logic [1:0] kind;
    } t_out_beat;

endpackage

// File: rtl/tar_header_stream_lister_core.sv
// tar header stream lister: walks a tar byte stream and reports entry names
`timescale 1ns / 1ps

// channel   direction  signals                      payload
// input     in         i_valid / o_ready / i_beat   archive_byte, stream_end
// result    out        o_valid / i_ready / o_beat   name_byte, kind
//
// one archive byte per cycle sustained while the result is taken; a byte is held in the
// input register and its result is registered in the result register (header logic)
// all work per byte is one pass through the header/skip update logic between
// the input register and the result register; the 37-bit skip decrement and
// the 37-bit block round-up add are the longest paths
// reset is synchronous and active low; it returns to the start of a header
// a stalled result holds the input register, and o_ready drops only while
// both registers are full and the result beat is not being taken
module tar_header_stream_lister_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  thsl_pkg::t_in_beat i_beat,
    output logic               o_valid,
    input  logic               i_ready,
    output thsl_pkg::t_out_beat o_beat
);
    import thsl_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SKIP,
        PH_DONE
    } t_phase;

    // input register
    logic        r_in_valid;
    t_in_beat    r_in_beat;

    // result register
    logic        r_out_valid;
    t_out_beat   r_out_beat;

    // walker state
    t_phase              r_phase,      n_phase;
    logic [OFFSET_W-1:0] r_offset,     n_offset;
    logic                r_name_open,  n_name_open;
    logic                r_name_any,   n_name_any;
    logic                r_all_zero,   n_all_zero;
    logic [SIZE_W-1:0]   r_size,       n_size;
    logic                r_size_done,  n_size_done;
    logic [SKIP_W-1:0]   r_skip,       n_skip;

    logic        w_proc;
    logic        w_emit;
    t_out_beat   w_res;

    logic [7:0]  w_b;
    logic        w_last;
    logic        w_zero;
    logic        w_name_here;
    logic        w_in_name;
    logic        w_in_size;
    logic        w_octal;
    logic [SKIP_W-1:0] w_skip_sum;
    logic [SKIP_W-1:0] w_skip_new;
    logic [SKIP_W-1:0] w_skip_dec;

    // process the held byte when the result slot is free or draining
    assign w_proc  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_proc;
    assign o_valid = r_out_valid;
    assign o_beat  = r_out_beat;

    assign w_b       = r_in_beat.archive_byte;
    assign w_last    = r_in_beat.stream_end;
    assign w_zero    = (w_b == 8'd0);
    assign w_in_name = (r_offset < NAME_LEN) && r_name_open;
    assign w_in_size = (r_offset >= SIZE_START) && (r_offset < SIZE_END) && !r_size_done;
    assign w_octal   = (w_b >= CHAR_ZERO) && (w_b <= CHAR_SEVEN);
    assign w_skip_dec = r_skip - SKIP_W'(1);

    // data length rounded up to whole blocks; the last header byte is outside
    // the size field, so the held size is already final there
    assign w_skip_sum = {1'b0, r_size} + SKIP_W'(BLOCK_LAST);
    assign w_skip_new = {w_skip_sum[SKIP_W-1:OFFSET_W], OFFSET_W'(0)};

    always_comb begin
        n_phase     = r_phase;
        n_offset    = r_offset;
        n_name_open = r_name_open;
        n_name_any  = r_name_any;
        n_all_zero  = r_all_zero;
        n_size      = r_size;
        n_size_done = r_size_done;
        n_skip      = r_skip;
        w_name_here = 1'b0;
        w_emit      = 1'b0;
        w_res       = '{name_byte: 8'd0, kind: KIND_NAME};

        unique case (r_phase)
            PH_SKIP: begin
                n_skip = w_skip_dec;
                if (w_last) begin
                    n_phase = PH_DONE;
                end else if (w_skip_dec == '0) begin
                    // data done, next header starts
                    n_phase     = PH_HEADER;
                    n_offset    = '0;
                    n_name_open = 1'b1;
                    n_name_any  = 1'b0;
                    n_all_zero  = 1'b1;
                    n_size      = '0;
                    n_size_done = 1'b0;
                end
            end
            PH_HEADER: begin
                if (!w_zero) begin
                    n_all_zero = 1'b0;
                end
                // name field: bytes up to the first nul
                if (w_in_name) begin
                    if (w_zero) begin
                        n_name_open = 1'b0;
                    end else begin
                        n_name_any  = 1'b1;
                        w_name_here = 1'b1;
                    end
                end
                // size field: octal digits up to the first nul
                if (w_in_size) begin
                    if (w_zero) begin
                        n_size_done = 1'b1;
                    end else if (w_octal) begin
                        n_size = {r_size[SIZE_W-4:0], w_b[2:0]};
                    end
                end

                priority if (r_offset == BLOCK_LAST) begin
                    if (n_all_zero) begin
                        // empty header marks the archive end
                        n_phase = PH_DONE;
                        w_emit  = 1'b1;
                        w_res   = '{name_byte: 8'd0, kind: KIND_END};
                    end else begin
                        w_emit      = n_name_any;
                        w_res       = '{name_byte: 8'd0, kind: KIND_COMMIT};
                        n_skip      = w_skip_new;
                        n_offset    = '0;
                        n_name_open = 1'b1;
                        n_name_any  = 1'b0;
                        n_all_zero  = 1'b1;
                        n_size      = '0;
                        n_size_done = 1'b0;
                        if (w_last) begin
                            n_phase = PH_DONE;
                        end else if (w_skip_new != '0) begin
                            n_phase = PH_SKIP;
                        end else begin
                            n_phase = PH_HEADER;
                        end
                    end
                end else if (w_last) begin
                    // truncated header: drop the pending name
                    n_phase = PH_DONE;
                    w_emit  = n_name_any;
                    w_res   = '{name_byte: 8'd0, kind: KIND_DISCARD};
                end else begin
                    n_offset = r_offset + OFFSET_W'(1);
                    w_emit   = w_name_here;
                    w_res    = '{name_byte: w_b, kind: KIND_NAME};
                end
            end
            PH_DONE: begin
                // trailing bytes are dropped
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_HEADER;
            r_offset    <= '0;
            r_name_open <= 1'b1;
            r_name_any  <= 1'b0;
            r_all_zero  <= 1'b1;
            r_size      <= '0;
            r_size_done <= 1'b0;
            r_skip      <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (o_ready && i_valid) begin
                r_in_beat <= i_beat;
            end
            if (w_proc) begin
                r_out_valid <= w_emit;
                if (w_emit) begin
                    r_out_beat <= w_res;
                end
                r_phase     <= n_phase;
                r_offset    <= n_offset;
                r_name_open <= n_name_open;
                r_name_any  <= n_name_any;
                r_all_zero  <= n_all_zero;
                r_size      <= n_size;
                r_size_done <= n_size_done;
                r_skip      <= n_skip;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // skipping always has data left to count down
    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SKIP |-> r_skip != '0)
        else $error("skip phase with zero count");

    // the header offset is parked at zero while data is skipped
    a_skip_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SKIP |-> r_offset == '0)
        else $error("header offset moved during skip");

    // only name beats carry a character
    a_marker_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_beat.kind != KIND_NAME |-> r_out_beat.name_byte == 8'd0)
        else $error("marker beat with nonzero byte");

    // an archive end marker leaves the walker finished
    a_end_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc && w_emit && w_res.kind == KIND_END |=> r_phase == PH_DONE)
        else $error("walker not finished after archive end");

endmodule
